### src/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the lenient UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int MAX_UNITS   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [7:0] LEAD_MASK = 8'hE0;
    localparam logic [7:0] LEAD3_MARK = 8'hE0;
    localparam logic [7:0] LEAD2_MARK = 8'hC0;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] CONT_BITS = 8'h3F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_req;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        out_last;
    } t_out_req;

    typedef struct packed {
        logic [1:0]                  count;
        logic [MAX_UNITS-1:0][15:0]  unit;
        logic                        last;
    } t_group;

    typedef struct packed {
        logic   valid;
        t_group group;
    } t_head;

endpackage

### src/utf8d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes, keeps the unfinished sequence and resolves each request
// into a group of up to three code units for the queue.
// ----------------------------------------------------------------------------
module utf8d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  utf8d_pkg::t_in_req i_in_req,
    input  logic              i_full,
    output logic              o_in_stall,
    output logic              o_push,
    output utf8d_pkg::t_group o_group
);

    logic [1:0][7:0] r_pend;
    logic [1:0]      r_cnt;
    logic [1:0][7:0] n_pend;
    logic [1:0]      n_cnt;
    logic            accept;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_MARK;
    endfunction

    function automatic logic is_lead3(input logic [7:0] b);
        return (b & utf8d_pkg::LEAD_MASK) == utf8d_pkg::LEAD3_MARK;
    endfunction

    function automatic logic is_lead2(input logic [7:0] b);
        return (b & utf8d_pkg::LEAD_MASK) == utf8d_pkg::LEAD2_MARK;
    endfunction

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        logic [7:0] b;
        logic [7:0] p0;
        logic [7:0] p1;
        logic       last;
        logic       solo;
        b    = i_in_req.in_byte;
        last = i_in_req.in_last;
        p0   = r_pend[0];
        p1   = r_pend[1];
        solo = 1'b0;
        o_group       = '0;
        o_group.last  = last;
        n_pend        = '0;
        n_cnt         = 2'd0;
        unique case (r_cnt)
            2'd1: begin
                if (is_lead2(p0) && is_cont(b)) begin
                    o_group.unit[0] = {5'd0, p0[4:0] & utf8d_pkg::LEAD2_BITS[4:0],
                                       b[5:0] & utf8d_pkg::CONT_BITS[5:0]};
                    o_group.count   = 2'd1;
                end else if (is_lead3(p0) && is_cont(b)) begin
                    if (last) begin
                        o_group.unit[0] = {8'd0, p0};
                        o_group.unit[1] = {8'd0, b};
                        o_group.count   = 2'd2;
                    end else begin
                        n_pend[0] = p0;
                        n_pend[1] = b;
                        n_cnt     = 2'd2;
                    end
                end else begin
                    o_group.unit[0] = {8'd0, p0};
                    o_group.count   = 2'd1;
                    solo            = 1'b1;
                end
            end
            2'd2: begin
                if (is_cont(b)) begin
                    o_group.unit[0] = {p0[3:0] & utf8d_pkg::LEAD3_BITS[3:0],
                                       p1[5:0] & utf8d_pkg::CONT_BITS[5:0],
                                       b[5:0] & utf8d_pkg::CONT_BITS[5:0]};
                    o_group.count   = 2'd1;
                end else begin
                    o_group.unit[0] = {8'd0, p0};
                    o_group.unit[1] = {8'd0, p1};
                    o_group.count   = 2'd2;
                    solo            = 1'b1;
                end
            end
            default: begin
                solo = 1'b1;
            end
        endcase
        if (solo) begin
            if ((is_lead2(b) || is_lead3(b)) && !last) begin
                n_pend[0] = b;
                n_cnt     = 2'd1;
            end else begin
                o_group.unit[o_group.count] = {8'd0, b};
                o_group.count               = o_group.count + 2'd1;
            end
        end
        o_push = accept && (o_group.count != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_pend <= '0;
        end else if (accept) begin
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
        end
    end

endmodule

### src/utf8d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_queue
// Short queue of resolved code-unit groups between the front and back.
// ----------------------------------------------------------------------------
module utf8d_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utf8d_pkg::t_group i_group,
    input  logic              i_pop,
    output logic              o_full,
    output utf8d_pkg::t_head  o_head
);

    localparam int PTR_W = $clog2(utf8d_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(utf8d_pkg::QUEUE_DEPTH + 1);

    utf8d_pkg::t_group r_mem [utf8d_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign o_full       = r_count == CNT_W'(utf8d_pkg::QUEUE_DEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.group = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(utf8d_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(utf8d_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

endmodule

### src/utf8d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_back
// Serializes the group at the head of the queue into one code unit per
// output request and releases the group after its final unit.
// ----------------------------------------------------------------------------
module utf8d_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utf8d_pkg::t_head   i_head,
    input  logic               i_out_stall,
    output logic               o_pop,
    output logic               o_out_valid,
    output utf8d_pkg::t_out_req o_out_req
);

    logic [1:0] r_idx;
    logic       take;
    logic       final_unit;

    assign final_unit  = r_idx == (i_head.group.count - 2'd1);
    assign take        = i_head.valid && !i_out_stall;
    assign o_pop       = take && final_unit;
    assign o_out_valid = i_head.valid;

    always_comb begin
        o_out_req.code_unit = i_head.group.unit[r_idx];
        o_out_req.out_last  = i_head.group.last && final_unit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= final_unit ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

### src/utf8_to_ucs2_lenient_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_lenient_decoder_core
// Lenient UTF-8 to UCS-2 decoder: bytes in, 16-bit code units out.
//
// Channel   Dir  Handshake                  Payload
// input     in   i_in_valid / o_in_stall    i_in_req  (in_byte, in_last)
// output    out  o_out_valid / i_out_stall  o_out_req (code_unit, out_last)
//
// A byte is accepted every cycle while the two-entry group queue has room.
// Each byte resolves in the front in its accept cycle into zero to three
// code units; the back gives one code unit per cycle while the output is
// not stalled, so a byte that yields n units takes n output transfers. The
// resolved group is registered in the queue, whose head the back reads.
// Reset clears the pending bytes and the queue. An output stall backs up
// the queue and then stalls the input.
module utf8_to_ucs2_lenient_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  utf8d_pkg::t_in_req  i_in_req,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output utf8d_pkg::t_out_req o_out_req,
    input  logic                i_out_stall
);

    logic              push;
    logic              pop;
    logic              full;
    utf8d_pkg::t_group group;
    utf8d_pkg::t_head  head;

    utf8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_group    (group)
    );

    utf8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (group),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    utf8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule

### verif/utf8_to_ucs2_lenient_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_lenient_decoder_core_test
// Self-checking bench for the lenient UTF-8 to UCS-2 decoder core.
//
// Byte requests are sent through the valid/stall input channel while a
// byte-level model of the greedy decoder computes the code units that each
// accepted byte must release. A monitor compares every accepted output
// request with the oldest predicted unit, field by field. Directed strings
// cover the byte extremes, well-formed and broken sequences and end-of-string
// flushes; random strings of mostly well-formed sequences follow, with random
// gaps on both sides and one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_lenient_decoder_core_test;

    localparam int HALF_PERIOD_NS = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int LONG_HOLD      = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_BYTES   = 100;
    localparam int PRESSURE_BYTES = 30;
    localparam int TIMEOUT_NS     = 5_000_000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    utf8d_pkg::t_in_req  i_in_req = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    utf8d_pkg::t_out_req o_out_req;
    logic                i_out_stall = 1'b0;

    logic [7:0]          pend_bytes [0:1];
    int                  pend_cnt = 0;
    utf8d_pkg::t_out_req units_due [$];
    logic [7:0]          str_bytes [$];

    int   bytes_sent = 0;
    int   strings_sent = 0;
    int   units_checked = 0;
    int   mismatches = 0;
    int   max_in_wait = 0;
    int   stall_left = 0;
    logic tx_gaps = 1'b1;
    logic rx_gaps = 1'b1;
    logic hold_ask = 1'b0;

    utf8_to_ucs2_lenient_decoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

    always begin
        #HALF_PERIOD_NS i_clk = 1'b1;
        #HALF_PERIOD_NS i_clk = 1'b0;
    end

    initial begin
        #TIMEOUT_NS;
        $display("%t: timeout with %0d code units still due", $time, units_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_MARK;
    endfunction

    // Appends the code units released by one accepted byte to units_due.
    task automatic decode_byte(input utf8d_pkg::t_in_req req);
        logic [7:0]          seq [0:2];
        logic [7:0]          b0;
        logic [15:0]         unit;
        logic                stop;
        int                  n;
        int                  pos;
        int                  left;
        int                  used;
        utf8d_pkg::t_out_req res;
        for (int i = 0; i < pend_cnt; i++) begin
            seq[i] = pend_bytes[i];
        end
        seq[pend_cnt] = req.in_byte;
        n = pend_cnt + 1;
        pos = 0;
        stop = 1'b0;
        while (pos < n && !stop) begin
            left = n - pos;
            b0 = seq[pos];
            unit = {8'h00, b0};
            used = 1;
            if ((b0 & utf8d_pkg::LEAD_MASK) == utf8d_pkg::LEAD3_MARK) begin
                if (left < 2) begin
                    stop = !req.in_last;
                end else if (is_cont(seq[pos+1])) begin
                    if (left < 3) begin
                        stop = !req.in_last;
                    end else if (is_cont(seq[pos+2])) begin
                        unit = {b0[3:0], seq[pos+1][5:0], seq[pos+2][5:0]};
                        used = 3;
                    end
                end
            end else if ((b0 & utf8d_pkg::LEAD_MASK) == utf8d_pkg::LEAD2_MARK) begin
                if (left < 2) begin
                    stop = !req.in_last;
                end else if (is_cont(seq[pos+1])) begin
                    unit = {5'b00000, b0[4:0], seq[pos+1][5:0]};
                    used = 2;
                end
            end
            if (!stop) begin
                res.code_unit = unit;
                res.out_last = req.in_last && (pos + used == n);
                units_due.push_back(res);
                pos = pos + used;
            end
        end
        pend_cnt = n - pos;
        for (int i = 0; i < pend_cnt; i++) begin
            pend_bytes[i] = seq[pos+i];
        end
    endtask

    // Offers one byte request and holds it until the core takes it.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int                 gap;
        int                 waited;
        utf8d_pkg::t_in_req req;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.in_byte = b;
        req.in_last = l;
        i_in_valid <= 1'b1;
        i_in_req <= req;
        waited = 0;
        @(posedge i_clk);
        while (o_in_stall) begin
            waited++;
            @(posedge i_clk);
        end
        if (waited > max_in_wait) begin
            max_in_wait = waited;
        end
        decode_byte(req);
        bytes_sent++;
        if (l) begin
            strings_sent++;
        end
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++) begin
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        end
    endtask

    // Mostly well-formed sequences, some truncated ones and some raw noise.
    task automatic build_string(input int max_tokens);
        int tokens;
        int kind;
        str_bytes.delete();
        tokens = $urandom_range(1, max_tokens);
        for (int t = 0; t < tokens; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                str_bytes.push_back(8'($urandom_range(1, 127)));
            end else if (kind < 60) begin
                str_bytes.push_back(utf8d_pkg::LEAD2_MARK | 8'($urandom_range(0, 31)));
                if ($urandom_range(0, 9) != 0) begin
                    str_bytes.push_back(utf8d_pkg::CONT_MARK | 8'($urandom_range(0, 63)));
                end
            end else if (kind < 85) begin
                str_bytes.push_back(utf8d_pkg::LEAD3_MARK | 8'($urandom_range(0, 15)));
                str_bytes.push_back(utf8d_pkg::CONT_MARK | 8'($urandom_range(0, 63)));
                if ($urandom_range(0, 9) != 0) begin
                    str_bytes.push_back(utf8d_pkg::CONT_MARK | 8'($urandom_range(0, 63)));
                end
            end else begin
                repeat ($urandom_range(1, 3)) str_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (units_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (hold_ask) begin
            hold_ask = 1'b0;
            stall_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (rx_gaps) begin
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_unit
        utf8d_pkg::t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (units_due.size() == 0) begin
                mismatches++;
                $display("%t: unexpected code unit: expected none, got %h last %b",
                         $time, o_out_req.code_unit, o_out_req.out_last);
            end else begin
                want = units_due.pop_front();
                units_checked++;
                if (o_out_req.code_unit !== want.code_unit) begin
                    mismatches++;
                    $display("%t: code_unit mismatch: expected %h, got %h",
                             $time, want.code_unit, o_out_req.code_unit);
                end
                if (o_out_req.out_last !== want.out_last) begin
                    mismatches++;
                    $display("%t: out_last mismatch: expected %b, got %b",
                             $time, want.out_last, o_out_req.out_last);
                end
            end
        end
    end

    task automatic test_ascii();
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h55, 1'b1);
        wait_idle();
    endtask

    task automatic test_two_byte();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b1);
        wait_idle();
    endtask

    task automatic test_three_byte();
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        wait_idle();
    endtask

    // A failed lead passes raw and decoding restarts at the very next byte;
    // a failed three-byte lead is never retried as a two-byte one.
    task automatic test_broken_sequences();
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        wait_idle();
    endtask

    // The end of a string fails every pending prefix and flushes it raw.
    task automatic test_string_end();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h80, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_strings();
        int stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            build_string(6);
            send_string();
            tx_gaps = 1'b1;
            rx_gaps = 1'b1;
        end
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_back_pressure();
        int stop_at;
        stop_at = bytes_sent + PRESSURE_BYTES;
        tx_gaps = 1'b0;
        hold_ask = 1'b1;
        while (bytes_sent < stop_at) begin
            build_string(4);
            send_string();
        end
        tx_gaps = 1'b1;
        wait_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_ascii();
        test_two_byte();
        test_three_byte();
        test_broken_sequences();
        test_string_end();
        test_back_pressure();
        test_random_strings();
        $display("Decoded %0d bytes in %0d strings; %0d code units were checked.",
                 bytes_sent, strings_sent, units_checked);
        $display("Longest input stall seen under output back-pressure: %0d cycles.",
                 max_in_wait);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
